// ----- rtl/imu_serial_frame_parser_core_macros.svh -----
// Assertion macros shared by the frame parser RTL.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ISFP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isfp assertion failed");

// next-cycle implication
`define ISFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isfp assertion failed");

`else

`define ISFP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ISFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/isfp_pkg.sv -----
// Types and constants of the IMU serial frame parser.
`default_nettype none

package isfp_pkg;

   localparam int FRAME_LENGTH  = 11;
   localparam int PAYLOAD_FIRST = 2;
   localparam int PAYLOAD_BYTES = 6;
   localparam int SHIFT_BITS    = 7;   // raw * scale / 32768 in Q.8 -> >>> 7

   localparam logic [7:0]  HEADER_BYTE      = 8'h55;
   localparam logic [7:0]  FRAME_TYPE_RESET = 8'h53;
   localparam logic [11:0] FULL_SCALE_RESET = 12'd180;

   localparam logic [3:0] LAST_POS      = 4'(FRAME_LENGTH - 1);
   localparam logic [3:0] PAYLOAD_START = 4'(PAYLOAD_FIRST);
   localparam logic [3:0] PAYLOAD_END   = 4'(PAYLOAD_FIRST + PAYLOAD_BYTES);

   // CSR indexes
   localparam logic CSR_FRAME_TYPE = 1'b0;
   localparam logic CSR_FULL_SCALE = 1'b1;

   typedef logic        [7:0]  byte_type;
   typedef logic        [11:0] scale_type;
   typedef logic signed [15:0] axis_raw_type;
   typedef logic signed [20:0] axis_value_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TYPE   = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic last;   // byte in the parse stage is the checksum byte
      logic ok;     // checksum byte matches the running sum
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/isfp_parser.sv -----
// Frame state machine, running checksum and axis byte store.
`default_nettype none

module isfp_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire isfp_pkg::byte_type    rx_byte,
   input  wire isfp_pkg::byte_type    frame_type,
   output isfp_pkg::status_type       status,
   output isfp_pkg::axis_raw_type     pitch_raw,
   output isfp_pkg::axis_raw_type     roll_raw,
   output isfp_pkg::axis_raw_type     yaw_raw
);
   import isfp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] pos_ff, pos_in;
   byte_type   sum_ff, sum_in;
   byte_type   payload_ff [PAYLOAD_BYTES];
   logic       wr_en;
   logic [2:0] wr_idx;
   logic       last;

   assign last   = (phase_ff == PH_BODY) && (pos_ff >= LAST_POS);
   assign status = '{last: last, ok: (sum_ff == rx_byte)};
   assign wr_idx = 3'(pos_ff - PAYLOAD_START);

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (rx_byte == HEADER_BYTE) phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (rx_byte == frame_type) phase_in = PH_BODY;
         end
         PH_BODY: begin
            if (last) phase_in = PH_HEADER;
         end
         default: begin
            phase_in = (rx_byte == HEADER_BYTE) ? PH_TYPE : PH_HEADER;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      wr_en  = 1'b0;
      unique case (phase_ff)
         PH_TYPE: begin
            if (rx_byte == frame_type) begin
               sum_in = sum_ff + rx_byte;
               pos_in = PAYLOAD_START;
            end
         end
         PH_BODY: begin
            if (!last) begin
               sum_in = sum_ff + rx_byte;
               pos_in = pos_ff + 4'd1;
               wr_en  = (pos_ff >= PAYLOAD_START) && (pos_ff < PAYLOAD_END);
            end else begin
               sum_in = '0;
               pos_in = '0;
            end
         end
         default: begin
            if (rx_byte == HEADER_BYTE) begin
               sum_in = HEADER_BYTE;
               pos_in = 4'd1;
            end else begin
               sum_in = '0;
               pos_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         payload_ff[wr_idx] <= rx_byte;
      end
   end

   // little-endian axes
   assign pitch_raw = {payload_ff[1], payload_ff[0]};
   assign roll_raw  = {payload_ff[3], payload_ff[2]};
   assign yaw_raw   = {payload_ff[5], payload_ff[4]};

endmodule

`default_nettype wire

// ----- rtl/isfp_scale.sv -----
// One axis: raw * full_scale / 32768, floored to Q.8.
`default_nettype none

module isfp_scale (
   input  wire isfp_pkg::axis_raw_type   raw,
   input  wire isfp_pkg::scale_type      full_scale,
   output isfp_pkg::axis_value_type      value
);
   import isfp_pkg::*;

   logic signed [27:0] prod;

   assign prod  = 28'(raw) * 28'($signed({1'b0, full_scale}));
   // arithmetic shift gives floor for negative products
   assign value = prod[27:SHIFT_BITS];

endmodule

`default_nettype wire

// ----- rtl/imu_serial_frame_parser_core.sv -----
// Top level of the IMU serial frame parser.
`default_nettype none
`include "imu_serial_frame_parser_core_macros.svh"

// Parses 11-byte IMU frames from a UART byte stream: header 0x55, the type
// byte set in frame_type, three little-endian signed 16-bit axes (pitch,
// roll, yaw), two bytes that only enter the checksum, then a checksum byte
// equal to the 8-bit sum of the ten bytes before it. One request carries one
// byte; the checksum byte of a frame yields one response with frame_ok and
// the three axes as raw * full_scale / 32768 in signed Q.8 (floored), or all
// axes zero when the checksum fails. Other bytes yield no response. Rate: one
// request per clock while the input stage is not stalled. A byte sits in the
// input register, where the parse logic and the three 16x12 multipliers act
// on it; the response of a checksum byte is registered in the output register.
// Only a checksum byte meeting a response that is still waiting stalls the
// input stage. Write the CSRs only while the block is idle.

module imu_serial_frame_parser_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire isfp_pkg::byte_type       req_rx_byte,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_frame_ok,
   output isfp_pkg::axis_value_type      rsp_pitch_value,
   output isfp_pkg::axis_value_type      rsp_roll_value,
   output isfp_pkg::axis_value_type      rsp_yaw_value,
   // CSR write port
   input  wire logic                     csr_write,
   input  wire logic                     csr_index,
   input  wire isfp_pkg::scale_type      csr_wdata
);
   import isfp_pkg::*;

   // CSRs
   byte_type        frame_type_ff;
   scale_type       full_scale_ff;

   // input register
   logic            in_valid_ff;
   byte_type        in_byte_ff;

   // output register
   logic            out_valid_ff;
   logic            out_ok_ff;
   axis_value_type  out_pitch_ff, out_roll_ff, out_yaw_ff;

   status_type      status;
   axis_raw_type    pitch_raw, roll_raw, yaw_raw;
   axis_value_type  pitch_scaled, roll_scaled, yaw_scaled;
   logic            advance;
   logic            step;
   logic            emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_type_ff <= FRAME_TYPE_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_TYPE: frame_type_ff <= csr_wdata[7:0];
            CSR_FULL_SCALE: full_scale_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // The parse stage moves on unless it would produce a response while the
   // output register is full and not being drained.
   assign advance   = !status.last || !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign emit      = step && status.last;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   isfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .frame_type (frame_type_ff),
      .status     (status),
      .pitch_raw  (pitch_raw),
      .roll_raw   (roll_raw),
      .yaw_raw    (yaw_raw)
   );

   isfp_scale u_scale_pitch (
      .raw        (pitch_raw),
      .full_scale (full_scale_ff),
      .value      (pitch_scaled)
   );

   isfp_scale u_scale_roll (
      .raw        (roll_raw),
      .full_scale (full_scale_ff),
      .value      (roll_scaled)
   );

   isfp_scale u_scale_yaw (
      .raw        (yaw_raw),
      .full_scale (full_scale_ff),
      .value      (yaw_scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // bad checksum: axes forced to zero
   always_ff @(posedge clock) begin
      if (emit) begin
         out_ok_ff    <= status.ok;
         out_pitch_ff <= status.ok ? pitch_scaled : '0;
         out_roll_ff  <= status.ok ? roll_scaled  : '0;
         out_yaw_ff   <= status.ok ? yaw_scaled   : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_ok    = out_ok_ff;
   assign rsp_pitch_value = out_pitch_ff;
   assign rsp_roll_value  = out_roll_ff;
   assign rsp_yaw_value   = out_yaw_ff;

   `ISFP_ASSERT_IMPLIES(a_bad_frame_zero, clock, reset, rsp_valid && !rsp_frame_ok, (rsp_pitch_value == '0) && (rsp_roll_value == '0) && (rsp_yaw_value == '0))
   `ISFP_ASSERT_IMPLIES(a_no_overwrite, clock, reset, out_valid_ff && !rsp_ready && in_valid_ff && status.last, !step)
   `ISFP_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid)

endmodule

`default_nettype wire
